// ----- rtl/abdr_pkg.sv -----
package abdr_pkg;

   localparam int MAP_BITS_DEFAULT = 65536;
   localparam int DIRTY_REGIONS_DEFAULT = 8;
   localparam logic [4:0] BLOCK_SIZE_LOG2_RESET = 5'd12;

   typedef enum logic [2:0] {
      CMD_SET       = 3'd0,
      CMD_CLEAR     = 3'd1,
      CMD_CLEAR_RUN = 3'd2,
      CMD_FIND      = 3'd3,
      CMD_LOAD      = 3'd4,
      CMD_READ      = 3'd5,
      CMD_TAKE      = 3'd6,
      CMD_BAD       = 3'd7
   } command_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NONE  = 2'd1,
      ST_RANGE = 2'd2,
      ST_SPARE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_WAIT,
      S_MOD,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] bit_index;
      logic [15:0] end_index;
      logic [16:0] bit_count;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_index;
      logic [31:0] read_data;
      logic [7:0]  dirty_mask;
   } rsp_type;

   // mask of bits lo..hi (inclusive) within a word
   function automatic logic [31:0] span_mask(input logic [4:0] lo, input logic [4:0] hi);
      logic [31:0] m;
      m = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi));
      return m;
   endfunction

endpackage

// ----- rtl/abdr_if.sv -----
interface abdr_req_if;
   logic               valid;
   logic               ready;
   abdr_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface abdr_rsp_if;
   logic               valid;
   logic               ready;
   abdr_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface abdr_csr_if;
   logic        valid;
   logic        ready;
   logic [4:0]  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/abdr_map_ram.sv -----
module abdr_map_ram #(
   parameter int WORDS = 2048,
   localparam int AW = $clog2(WORDS)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data
);
   logic [31:0] mem [WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/allocation_bitmap_dirty_regions.sv -----
// Bitmap of MAP_BITS bits held in a simple dual-port word RAM (one read, one
// write per cycle, registered read data), plus DIRTY_REGIONS dirty flags in
// flip-flops. One item is processed at a time. Set and clear take a read,
// a wait and a write, then the response. Clear run and find walk the span one
// 32-bit word at a time, each word taking a read, a wait and a modify/write
// step. The map RAM has no reset; a word must be loaded or written before it
// is read.
module allocation_bitmap_dirty_regions #(
   parameter int MAP_BITS = abdr_pkg::MAP_BITS_DEFAULT,
   parameter int DIRTY_REGIONS = abdr_pkg::DIRTY_REGIONS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   abdr_req_if.sink      req,
   abdr_rsp_if.source    rsp,
   abdr_csr_if.sink      csr
);
   localparam int WORDS = (MAP_BITS + 31) / 32;
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int RW = (DIRTY_REGIONS > 1) ? $clog2(DIRTY_REGIONS) : 1;

   abdr_pkg::state_type state_ff, state_in;
   abdr_pkg::req_type   cur_ff, cur_in;
   abdr_pkg::rsp_type   rsp_ff, rsp_in;
   logic [4:0]          bsl_ff;
   logic [DIRTY_REGIONS-1:0] dirty_ff, dirty_in;
   logic [16:0]         pos_ff, pos_in;     // current bit position
   logic [17:0]         last_ff, last_in;   // inclusive last bit, plus one guard
   logic [AW-1:0]       rd_addr;
   logic                rd_en, wr_en;
   logic [31:0]         rd_data, wr_data;
   logic [AW-1:0]       wr_addr;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bsl_ff <= abdr_pkg::BLOCK_SIZE_LOG2_RESET;
      end else if (csr.valid) begin
         bsl_ff <= csr.payload;
      end
   end

   abdr_map_ram #(.WORDS(WORDS)) u_ram (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   // flag of the region that holds bit b
   function automatic logic [DIRTY_REGIONS-1:0] region_of(input logic [16:0] b,
                                                          input logic [4:0] bsl);
      logic [DIRTY_REGIONS-1:0] r;
      logic [5:0] sh;
      logic [16:0] idx;
      r = '0;
      sh = {1'b0, bsl} + 6'd3;
      idx = (sh >= 6'd17) ? 17'd0 : (b >> sh);
      if (idx < 17'(DIRTY_REGIONS)) begin
         r[idx[RW-1:0]] = 1'b1;
      end
      return r;
   endfunction

   // every region from the one holding bit a through the one holding bit z
   function automatic logic [DIRTY_REGIONS-1:0] region_span(input logic [16:0] a,
                                                            input logic [16:0] z,
                                                            input logic [4:0] bsl);
      logic [DIRTY_REGIONS-1:0] r;
      logic [5:0] sh;
      logic [16:0] ra, rz;
      sh = {1'b0, bsl} + 6'd3;
      ra = (sh >= 6'd17) ? 17'd0 : (a >> sh);
      rz = (sh >= 6'd17) ? 17'd0 : (z >> sh);
      for (int k = 0; k < DIRTY_REGIONS; k++) begin
         r[k] = (17'(k) >= ra) && (17'(k) <= rz);
      end
      return r;
   endfunction

   logic [31:0] mask_w;
   logic [4:0]  lo_b, hi_b;
   logic [31:0] zeros;
   logic [4:0]  first_zero;
   logic        any_zero;
   logic [16:0] word_end;

   assign req.ready = (state_ff == abdr_pkg::S_IDLE);
   assign rsp.valid = (state_ff == abdr_pkg::S_RESP);
   assign rsp.payload = rsp_ff;

   always_comb begin
      word_end = {pos_ff[16:5], 5'd31};
      lo_b = pos_ff[4:0];
      hi_b = ({1'b0, word_end} > last_ff) ? last_ff[4:0] : 5'd31;
      mask_w = abdr_pkg::span_mask(lo_b, hi_b);
      zeros = ~rd_data & mask_w;
      first_zero = '0;
      any_zero = |zeros;
      for (int i = 31; i >= 0; i--) begin
         if (zeros[i]) first_zero = 5'(i);
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      rsp_in = rsp_ff;
      dirty_in = dirty_ff;
      pos_in = pos_ff;
      last_in = last_ff;
      rd_en = 1'b0;
      rd_addr = pos_ff[AW+4:5];
      wr_en = 1'b0;
      wr_addr = pos_ff[AW+4:5];
      wr_data = rd_data;
      unique case (state_ff)
         abdr_pkg::S_IDLE: begin
            if (req.valid) begin
               cur_in = req.payload;
               rsp_in = '0;
               pos_in = {1'b0, req.payload.bit_index};
               state_in = abdr_pkg::S_RESP;
               unique case (abdr_pkg::command_type'(req.payload.command))
                  abdr_pkg::CMD_SET, abdr_pkg::CMD_CLEAR, abdr_pkg::CMD_READ: begin
                     if (32'(req.payload.bit_index) >= 32'(MAP_BITS))
                        rsp_in.status = abdr_pkg::ST_RANGE;
                     else state_in = abdr_pkg::S_RD;
                  end
                  abdr_pkg::CMD_LOAD: begin
                     if (32'(req.payload.bit_index) >= 32'(MAP_BITS))
                        rsp_in.status = abdr_pkg::ST_RANGE;
                     else state_in = abdr_pkg::S_MOD;
                  end
                  abdr_pkg::CMD_CLEAR_RUN: begin
                     last_in = 18'(req.payload.bit_index) + 18'(req.payload.bit_count)
                               - 18'd1;
                     if (32'(req.payload.bit_index) + 32'(req.payload.bit_count)
                         > 32'(MAP_BITS))
                        rsp_in.status = abdr_pkg::ST_RANGE;
                     else if (req.payload.bit_count != '0) state_in = abdr_pkg::S_RD;
                  end
                  abdr_pkg::CMD_FIND: begin
                     last_in = 18'(req.payload.end_index);
                     if (32'(req.payload.bit_index) >= 32'(MAP_BITS) ||
                         32'(req.payload.end_index) >= 32'(MAP_BITS))
                        rsp_in.status = abdr_pkg::ST_RANGE;
                     else if (req.payload.end_index < req.payload.bit_index)
                        rsp_in.status = abdr_pkg::ST_NONE;
                     else state_in = abdr_pkg::S_RD;
                  end
                  abdr_pkg::CMD_TAKE: begin
                     for (int i = 0; i < DIRTY_REGIONS && i < 8; i++)
                        rsp_in.dirty_mask[i] = dirty_ff[i];
                     dirty_in = '0;
                  end
                  abdr_pkg::CMD_BAD: rsp_in.status = abdr_pkg::ST_RANGE;
                  default: rsp_in.status = abdr_pkg::ST_RANGE;
               endcase
            end
         end
         abdr_pkg::S_RD: begin
            rd_en = 1'b1;
            state_in = abdr_pkg::S_WAIT;
         end
         abdr_pkg::S_WAIT: state_in = abdr_pkg::S_MOD;
         abdr_pkg::S_MOD: begin
            state_in = abdr_pkg::S_RESP;
            unique case (abdr_pkg::command_type'(cur_ff.command))
               abdr_pkg::CMD_SET, abdr_pkg::CMD_CLEAR: begin
                  wr_en = 1'b1;
                  wr_data = rd_data;
                  wr_data[pos_ff[4:0]] = (cur_ff.command == abdr_pkg::CMD_SET);
                  dirty_in = dirty_ff | region_of(pos_ff, bsl_ff);
               end
               abdr_pkg::CMD_LOAD: begin
                  wr_en = 1'b1;
                  wr_data = cur_ff.load_data;
               end
               abdr_pkg::CMD_READ: rsp_in.read_data = rd_data;
               abdr_pkg::CMD_CLEAR_RUN: begin
                  wr_en = 1'b1;
                  wr_data = rd_data & ~mask_w;
                  // mark every region from the first to the last bit of this word's part of the span
                  dirty_in = dirty_ff
                             | region_span(pos_ff, {pos_ff[16:5], hi_b}, bsl_ff);
                  if ({1'b0, word_end} < last_ff) begin
                     pos_in = word_end + 17'd1;
                     state_in = abdr_pkg::S_RD;
                  end
               end
               abdr_pkg::CMD_FIND: begin
                  if (any_zero) begin
                     rsp_in.found_index = {pos_ff[15:5], first_zero};
                  end else if ({1'b0, word_end} < last_ff) begin
                     pos_in = word_end + 17'd1;
                     state_in = abdr_pkg::S_RD;
                  end else begin
                     rsp_in.status = abdr_pkg::ST_NONE;
                  end
               end
               default: ;
            endcase
         end
         abdr_pkg::S_RESP: begin
            if (rsp.ready) state_in = abdr_pkg::S_IDLE;
         end
         default: state_in = abdr_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abdr_pkg::S_IDLE;
         dirty_ff <= '0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
      pos_ff <= pos_in;
      last_ff <= last_in;
   end
endmodule

// ----- rtl/abdr_checker.sv -----
module abdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status
);
   // never accept while a response is pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept during response");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != abdr_pkg::ST_SPARE) else $error("bad status");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule

bind allocation_bitmap_dirty_regions abdr_checker u_abdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_status(rsp.payload.status)
);
